[rtl/core/cvlc_pkg.sv]
// shared types and constants for the coefficient run vlc encoder
`default_nettype none

package cvlc_pkg;

	localparam int unsigned CodeWidth  = 20;
	localparam int unsigned AccWidth   = 27;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

	localparam logic [4:0]  RunChunk    = 5'd16;
	localparam logic [3:0]  RunFullCode = 4'hF;
	localparam logic [10:0] CoeffMin    = 11'sh401;
	localparam logic [10:0] CoeffLowest = 11'sh400;

	localparam logic MODE_COEFF = 1'b0;
	localparam logic MODE_EOP   = 1'b1;

	// up to three packed bytes, first byte in the top bits
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[rtl/core/cvlc_front.sv]
// front: classifies coefficients, builds code words and packs them into bytes
`default_nettype none

module cvlc_front
	import cvlc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        coeff_valid,
	output logic             coeff_stall,
	input  wire logic        mode,
	input  wire logic [10:0] coeff_value,
	input  wire q_status_t   q_status,
	output logic             push,
	output q_entry_t         push_entry
);

	logic [4:0]  zero_run_q;
	logic        valid_s1;
	logic [CodeWidth-1:0] code_s1;
	logic [4:0]  len_s1;
	logic        eop_s1;
	logic [6:0]  pend_bits_q;
	logic [2:0]  pend_cnt_q;

	logic        accept;
	logic        advance;
	logic        is_eop;
	logic [10:0] v_sat;
	logic [10:0] v_eff;
	logic [10:0] v_neg;
	logic [10:0] v_m1;
	logic        neg;
	logic [9:0]  mag;
	logic [3:0]  size;
	logic [10:0] mask11;
	logic [9:0]  mbits;
	logic [3:0]  hdr;
	logic [4:0]  hlen;
	logic [13:0] tail;
	logic [4:0]  tail_len;
	logic [5:0]  chunk;
	logic        have_run;
	logic [CodeWidth-1:0] code_d;
	logic [4:0]  len_d;
	logic [4:0]  zero_run_d;

	logic [4:0]  total;
	logic [AccWidth-1:0] acc;
	logic [AccWidth-1:0] aligned;
	logic [5:0]  total_up;
	logic [1:0]  nbytes;
	logic [7:0]  mask8;

	// stage 1: classify and build the code word
	always_comb begin
		is_eop   = (mode == MODE_EOP);
		v_sat    = (coeff_value == CoeffLowest) ? CoeffMin : coeff_value;
		v_eff    = is_eop ? 11'd1 : v_sat;
		neg      = v_eff[10];
		v_neg    = 11'd0 - v_eff;
		mag      = neg ? v_neg[9:0] : v_eff[9:0];
		size     = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (mag[i]) begin
				size = 4'(i + 1);
			end
		end
		mask11   = (11'd1 << size) - 11'd1;
		v_m1     = v_eff - 11'd1;
		// negatives go out as value + 2^size - 1, i.e. the low bits of value - 1
		mbits    = (neg ? v_m1[9:0] : v_eff[9:0]) & mask11[9:0];
		if (size < 4'd3) begin
			hdr  = {1'b0, 3'(size + 4'd1)};
			hlen = 5'd3;
		end else begin
			hdr  = size + 4'd5;
			hlen = 5'd4;
		end
		tail     = (14'(hdr) << size) | 14'(mbits);
		tail_len = hlen + 5'(size);
		have_run = (zero_run_q != 5'd0);
		chunk    = {2'b00, 4'(zero_run_q - 5'd1)};

		if (!is_eop && mag == 10'd0) begin
			// zero: a full chunk leaves as soon as the run would pass 16
			if (zero_run_q == RunChunk) begin
				code_d     = CodeWidth'({2'b00, RunFullCode});
				len_d      = 5'd6;
				zero_run_d = 5'd1;
			end else begin
				code_d     = '0;
				len_d      = 5'd0;
				zero_run_d = zero_run_q + 5'd1;
			end
		end else begin
			if (have_run) begin
				code_d = (CodeWidth'(chunk) << tail_len) | CodeWidth'(tail);
				len_d  = tail_len + 5'd6;
			end else begin
				code_d = CodeWidth'(tail);
				len_d  = tail_len;
			end
			zero_run_d = 5'd0;
		end
	end

	// stage 2: merge with pending bits and cut whole bytes
	always_comb begin
		total    = 5'(pend_cnt_q) + len_s1;
		acc      = (AccWidth'(pend_bits_q) << len_s1) | AccWidth'(code_s1);
		aligned  = acc << (5'(AccWidth) - total);
		total_up = 6'(total) + 6'd7;
		nbytes   = eop_s1 ? total_up[4:3] : total[4:3];
		mask8    = (8'd1 << total[2:0]) - 8'd1;
		push_entry.bytes  = aligned[AccWidth-1 -: 24];
		push_entry.nbytes = nbytes;
	end

	assign coeff_stall = valid_s1 && (nbytes != 2'd0) && q_status.full;
	assign advance     = !coeff_stall;
	assign accept      = coeff_valid && !coeff_stall;
	assign push        = valid_s1 && (nbytes != 2'd0) && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q  <= 5'd0;
			valid_s1    <= 1'b0;
			pend_bits_q <= 7'd0;
			pend_cnt_q  <= 3'd0;
		end else begin
			if (accept) begin
				zero_run_q <= zero_run_d;
				valid_s1   <= 1'b1;
			end else if (advance) begin
				valid_s1   <= 1'b0;
			end
			if (valid_s1 && advance) begin
				if (eop_s1) begin
					pend_bits_q <= 7'd0;
					pend_cnt_q  <= 3'd0;
				end else begin
					pend_bits_q <= acc[6:0] & mask8[6:0];
					pend_cnt_q  <= total[2:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= code_d;
			len_s1  <= len_d;
			eop_s1  <= is_eop;
		end
	end

endmodule

`default_nettype wire

[rtl/core/cvlc_queue.sv]
// short queue of packed byte groups between front and back
`default_nettype none

module cvlc_queue
	import cvlc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire q_entry_t  push_entry,
	input  wire logic      pop,
	output q_entry_t       head,
	output q_status_t      status
);

	q_entry_t              mem_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueuePtrW:0]    count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

[rtl/core/cvlc_back.sv]
// back: sends queued byte groups one byte per cycle through an output register, while byte_stall is low
`default_nettype none

module cvlc_back
	import cvlc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire q_entry_t   head,
	input  wire q_status_t  q_status,
	output logic            pop,
	output logic            byte_valid,
	input  wire logic       byte_stall,
	output logic [7:0]      out_byte,
	output logic            last
);

	logic        cur_valid_q;
	logic [23:0] cur_bytes_q;
	logic [1:0]  cur_left_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic load_out;
	logic final_byte;

	assign load_out   = cur_valid_q && (!out_valid_q || !byte_stall);
	assign final_byte = load_out && (cur_left_q == 2'd1);
	assign pop        = !q_status.empty && (!cur_valid_q || final_byte);

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (final_byte) begin
				cur_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= head.bytes;
			cur_left_q  <= head.nbytes;
		end else if (load_out) begin
			cur_bytes_q <= cur_bytes_q << 8;
			cur_left_q  <= cur_left_q - 2'd1;
		end
		if (load_out) begin
			out_byte_q <= cur_bytes_q[23:16];
			last_q     <= (cur_left_q == 2'd1);
		end
	end

endmodule

`default_nettype wire

[rtl/core/coefficient_run_vlc_encoder_core.sv]
// top level of the coefficient run vlc encoder
//
// coefficient channel: coeff_valid / coeff_stall with mode and coeff_value;
//   an item is taken at a clock edge with coeff_valid high and coeff_stall low
// byte channel: byte_valid / byte_stall with out_byte and last; last marks
//   the final byte that one coefficient item produced, items that complete
//   no byte produce nothing on this channel
// mode end of plane codes the value 1, pads the partial byte with zeros and
//   sends it, then clears the run and bit state
// path: the first byte of an item reaches the byte port through the stage 1
//   register, the queue, the current group register and the output register
// throughput: the back end sends one byte per cycle while byte_stall is low,
//   so an item that makes up to three bytes bounds the sustained item rate;
//   the front takes one item per cycle while the 4-deep queue has room
// reset: arst_n clears the zero run, pending bits, queue and output valid
// stall: while byte_stall is high the output register holds; the queue
//   fills, and the front raises coeff_stall only when an item needs a slot
//   and none is free
`default_nettype none

module coefficient_run_vlc_encoder_core
	import cvlc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        coeff_valid,
	output logic             coeff_stall,
	input  wire logic        mode,
	input  wire logic [10:0] coeff_value,
	output logic             byte_valid,
	input  wire logic        byte_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_status;
	logic      push;
	logic      pop;

	// front: code word build and byte packing, owns run and bit state
	cvlc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.coeff_valid (coeff_valid),
		.coeff_stall (coeff_stall),
		.mode        (mode),
		.coeff_value (coeff_value),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	// groups of one to three finished bytes
	cvlc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back: serializes each group onto the byte port
	cvlc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule

`default_nettype wire
